// ===== rtl/wfts_pkg.sv =====
// Package with constants, types and helpers shared by the fusion top-k select block.
package wfts_pkg;

  localparam int unsigned MaxItems  = 8;
  localparam int unsigned TopCount  = 4;
  localparam int unsigned FifoDepth = 4;

  localparam int unsigned TakenW = $clog2(MaxItems + 1);
  localparam int unsigned RankW  = (TopCount > 1) ? $clog2(TopCount) : 1;
  localparam int unsigned PtrW   = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CountW = $clog2(FifoDepth + 1);

  localparam int unsigned WeightW = 9;
  localparam int unsigned ScoreInW = 24;
  localparam int unsigned ProdW = WeightW + 1 + ScoreInW;
  localparam int unsigned TermW = ProdW - 8;

  localparam logic [WeightW-1:0] DenseWeightRst  = 9'd154;
  localparam logic [WeightW-1:0] SparseWeightRst = 9'd102;

  localparam logic signed [31:0] EmptyId    = -32'sd1;
  localparam logic signed [31:0] EmptyScore = -32'sd2147483000;

  localparam logic CfgDenseWeight  = 1'b0;
  localparam logic CfgSparseWeight = 1'b1;

  typedef struct packed {
    logic signed [31:0] score;
    logic signed [31:0] doc;
    logic               use_cand;
    logic               is_last;
  } cand_entry_t;

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_EMIT    = 2'b10
  } back_state_e;

  // Divides a Q8 product by 256 with truncation toward zero.
  function automatic logic signed [TermW-1:0] q8_trunc(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] adj;
    adj = p + ((p < 0) ? ProdW'(255) : ProdW'(0));
    return TermW'(adj >>> 8);
  endfunction

endpackage

// ===== rtl/wfts_if.sv =====
// Valid/ready channel interfaces for candidate items and ranked results.
interface wfts_in_if;
  logic                valid;
  logic                ready;
  logic [30:0]         doc_id;
  logic signed [23:0]  dense_score;
  logic signed [23:0]  sparse_score;
  logic [1:0]          source_mask;
  logic                has_candidate;
  logic                is_last;

  modport source (output valid, doc_id, dense_score, sparse_score, source_mask,
                  has_candidate, is_last, input ready);
  modport sink (input valid, doc_id, dense_score, sparse_score, source_mask,
                has_candidate, is_last, output ready);
endinterface

interface wfts_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          rank;
  logic signed [31:0]  ranked_doc;
  logic signed [31:0]  ranked_score;
  logic                run_last;

  modport source (output valid, rank, ranked_doc, ranked_score, run_last, input ready);
  modport sink (input valid, rank, ranked_doc, ranked_score, run_last, output ready);
endinterface

// ===== rtl/wfts_front.sv =====
// Front end: weight registers, candidate intake, set counting and score fusion.
module wfts_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [wfts_pkg::WeightW-1:0]      cfg_data_i,
  wfts_in_if.sink                           in_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output wfts_pkg::cand_entry_t             push_entry_o
);

  logic [wfts_pkg::WeightW-1:0] dense_w_q, sparse_w_q;
  logic [wfts_pkg::TakenW-1:0]  taken_q, taken_d;
  logic                         stg_valid_q, stg_valid_d;
  logic signed [wfts_pkg::ProdW-1:0] prod_dense_q, prod_sparse_q;
  logic signed [wfts_pkg::ProdW-1:0] prod_dense_d, prod_sparse_d;
  logic signed [31:0]           doc_q;
  logic                         use_q, last_q;
  logic                         accept, push, use_d;
  logic signed [wfts_pkg::TermW-1:0] term_dense, term_sparse;

  assign in_i.ready = !stg_valid_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push       = stg_valid_q && push_ready_i;
  assign use_d      = in_i.has_candidate && (taken_q < wfts_pkg::TakenW'(wfts_pkg::MaxItems));

  always_comb begin
    prod_dense_d  = '0;
    prod_sparse_d = '0;
    if (in_i.source_mask[0]) begin
      prod_dense_d = wfts_pkg::ProdW'($signed({1'b0, dense_w_q}) * in_i.dense_score);
    end
    if (in_i.source_mask[1]) begin
      prod_sparse_d = wfts_pkg::ProdW'($signed({1'b0, sparse_w_q}) * in_i.sparse_score);
    end
  end

  always_comb begin
    taken_d = taken_q;
    if (accept) begin
      if (in_i.is_last) begin
        taken_d = '0;
      end else if (use_d) begin
        taken_d = taken_q + wfts_pkg::TakenW'(1);
      end
    end
    stg_valid_d = accept ? 1'b1 : (push ? 1'b0 : stg_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dense_w_q   <= wfts_pkg::DenseWeightRst;
      sparse_w_q  <= wfts_pkg::SparseWeightRst;
      taken_q     <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == wfts_pkg::CfgDenseWeight) begin
        dense_w_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == wfts_pkg::CfgSparseWeight) begin
        sparse_w_q <= cfg_data_i;
      end
      taken_q     <= taken_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_dense_q  <= prod_dense_d;
      prod_sparse_q <= prod_sparse_d;
      doc_q         <= $signed({1'b0, in_i.doc_id});
      use_q         <= use_d;
      last_q        <= in_i.is_last;
    end
  end

  assign term_dense  = wfts_pkg::q8_trunc(prod_dense_q);
  assign term_sparse = wfts_pkg::q8_trunc(prod_sparse_q);

  assign push_valid_o          = stg_valid_q;
  assign push_entry_o.score    = 32'(term_dense) + 32'(term_sparse);
  assign push_entry_o.doc      = doc_q;
  assign push_entry_o.use_cand = use_q;
  assign push_entry_o.is_last  = last_q;

endmodule

// ===== rtl/wfts_fifo.sv =====
// Short queue of fused candidates between the front end and the ranking back end.
module wfts_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  output logic                   push_ready_o,
  input  wfts_pkg::cand_entry_t  push_entry_i,
  output logic                   pop_valid_o,
  input  logic                   pop_ready_i,
  output wfts_pkg::cand_entry_t  pop_entry_o
);

  wfts_pkg::cand_entry_t         mem_q [wfts_pkg::FifoDepth];
  logic [wfts_pkg::PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [wfts_pkg::CountW-1:0]   count_q;
  logic                          push, pop;

  assign push_ready_o = count_q < wfts_pkg::CountW'(wfts_pkg::FifoDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == wfts_pkg::PtrW'(wfts_pkg::FifoDepth - 1)) ?
                    '0 : wr_ptr_q + wfts_pkg::PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == wfts_pkg::PtrW'(wfts_pkg::FifoDepth - 1)) ?
                    '0 : rd_ptr_q + wfts_pkg::PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + wfts_pkg::CountW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - wfts_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== rtl/wfts_back.sv =====
// Back end: sorted top-k list update and ranked result emission.
module wfts_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  wfts_pkg::cand_entry_t  pop_entry_i,
  wfts_out_if.source             out_o
);

  wfts_pkg::back_state_e         state_q, state_d;
  logic signed [31:0]            ids_q [wfts_pkg::TopCount];
  logic signed [31:0]            scores_q [wfts_pkg::TopCount];
  logic signed [31:0]            ins_ids [wfts_pkg::TopCount];
  logic signed [31:0]            ins_scores [wfts_pkg::TopCount];
  logic signed [31:0]            prev_ids [wfts_pkg::TopCount];
  logic signed [31:0]            prev_scores [wfts_pkg::TopCount];
  logic [wfts_pkg::TopCount-1:0] beat_vec, hit_vec;
  logic [wfts_pkg::RankW-1:0]    rank_q;
  logic                          out_valid_q;
  logic [1:0]                    out_rank_q;
  logic signed [31:0]            out_doc_q, out_score_q;
  logic                          out_last_q;
  logic                          pop, load, final_rank;

  assign pop_ready_o = (state_q == wfts_pkg::ST_COLLECT);
  assign pop         = pop_valid_i && pop_ready_o;
  assign load        = (state_q == wfts_pkg::ST_EMIT) && (!out_valid_q || out_o.ready);
  assign final_rank  = (rank_q == wfts_pkg::RankW'(wfts_pkg::TopCount - 1));

  always_comb begin
    prev_ids[0]    = wfts_pkg::EmptyId;
    prev_scores[0] = wfts_pkg::EmptyScore;
    for (int k = 1; k < wfts_pkg::TopCount; k++) begin
      prev_ids[k]    = ids_q[k-1];
      prev_scores[k] = scores_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < wfts_pkg::TopCount; k++) begin
      beat_vec[k] = (pop_entry_i.score > scores_q[k]) ||
                    ((pop_entry_i.score == scores_q[k]) &&
                     ((pop_entry_i.doc < ids_q[k]) || (ids_q[k] < 0)));
    end
    hit_vec[0] = 1'b0;
    for (int k = 1; k < wfts_pkg::TopCount; k++) begin
      hit_vec[k] = hit_vec[k-1] || beat_vec[k-1];
    end
    for (int k = 0; k < wfts_pkg::TopCount; k++) begin
      if (hit_vec[k]) begin
        ins_ids[k]    = prev_ids[k];
        ins_scores[k] = prev_scores[k];
      end else if (beat_vec[k]) begin
        ins_ids[k]    = pop_entry_i.doc;
        ins_scores[k] = pop_entry_i.score;
      end else begin
        ins_ids[k]    = ids_q[k];
        ins_scores[k] = scores_q[k];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wfts_pkg::ST_COLLECT: begin
        if (pop && pop_entry_i.is_last) begin
          state_d = wfts_pkg::ST_EMIT;
        end
      end
      wfts_pkg::ST_EMIT: begin
        if (load && final_rank) begin
          state_d = wfts_pkg::ST_COLLECT;
        end
      end
      default: state_d = wfts_pkg::ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wfts_pkg::ST_COLLECT;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < wfts_pkg::TopCount; k++) begin
        ids_q[k]    <= wfts_pkg::EmptyId;
        scores_q[k] <= wfts_pkg::EmptyScore;
      end
    end else begin
      state_q <= state_d;
      if (pop && pop_entry_i.use_cand) begin
        for (int k = 0; k < wfts_pkg::TopCount; k++) begin
          ids_q[k]    <= ins_ids[k];
          scores_q[k] <= ins_scores[k];
        end
      end
      if (pop && pop_entry_i.is_last) begin
        rank_q <= '0;
      end
      if (load) begin
        rank_q <= final_rank ? '0 : rank_q + wfts_pkg::RankW'(1);
        if (final_rank) begin
          for (int k = 0; k < wfts_pkg::TopCount; k++) begin
            ids_q[k]    <= wfts_pkg::EmptyId;
            scores_q[k] <= wfts_pkg::EmptyScore;
          end
        end
      end
      out_valid_q <= load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_rank_q  <= 2'(rank_q);
      out_doc_q   <= ids_q[rank_q];
      out_score_q <= scores_q[rank_q];
      out_last_q  <= final_rank;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.rank         = out_rank_q;
  assign out_o.ranked_doc   = out_doc_q;
  assign out_o.ranked_score = out_score_q;
  assign out_o.run_last     = out_last_q;

endmodule

// ===== rtl/weighted_fusion_top4_select_unit.sv =====
// Top level of the weighted score fusion and top-4 selection block.
//
// Channel   Direction  Transfer
// in_i      sink       one candidate item: id, dense and sparse scores, mask, flags
// out_o     source     one ranked result: rank, document id, fused score, run_last
// cfg       write      dense weight (index 0) or sparse weight (index 1)
//
// A candidate is accepted each cycle while the staging register or the queue has room.
// An item passes through the staging register and the queue to the back end and updates the list there.
// A last item holds the back end for four output loads, one per rank.
// Rank 0 is loaded into the output register once the back end has entered its emit state after the last item.
// The list starts filling again once the last rank has been loaded into the output register.
// Reset restores the default weights and an empty list; there is no clearing pass.
module weighted_fusion_top4_select_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [wfts_pkg::WeightW-1:0]  cfg_data_i,
  wfts_in_if.sink                       in_i,
  wfts_out_if.source                    out_o
);

  logic                   push_valid, push_ready;
  logic                   pop_valid, pop_ready;
  wfts_pkg::cand_entry_t  push_entry, pop_entry;

  wfts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  wfts_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  wfts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_o       (out_o)
  );

endmodule
